// ===== design/rbd_pkg.sv =====
// Shared types, constants and the control store for the rANS byte decoder.
// No dependencies; rans_byte_decoder imports this package.
package rbd_pkg;

   localparam int TABLE_LOG = 12;
   localparam int LB_LOG = 31;
   localparam int TABLE_SIZE = 1 << TABLE_LOG;
   localparam int STATE_W = 64;
   localparam int SYM_W = 8;
   localparam int FREQ_W = TABLE_LOG + 1;
   localparam int Q_W = LB_LOG + 8 - TABLE_LOG;
   localparam int PROD_W = FREQ_W + Q_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int UPC_W = 3;

   localparam logic [STATE_W-1:0] L_STATE = STATE_W'(1) << LB_LOG;
   localparam logic [STATE_W-1:0] U_STATE = STATE_W'(1) << (LB_LOG + 8);
   localparam logic [SUM_W-1:0] L_SUM = SUM_W'(1) << LB_LOG;
   localparam logic [SUM_W-1:0] U_SUM = SUM_W'(1) << (LB_LOG + 8);

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_TRUNC = 3'd1;
   localparam logic [2:0] ERR_STATE = 3'd2;
   localparam logic [2:0] ERR_TABLE = 3'd3;
   localparam logic [2:0] ERR_OVF = 3'd4;
   localparam logic [2:0] ERR_TERM = 3'd5;
   localparam logic [2:0] ERR_TRAIL = 3'd6;

   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_IDLE = 3'd0;
   localparam upc_type UPC_LOAD = 3'd1;
   localparam upc_type UPC_START = 3'd2;
   localparam upc_type UPC_DEC_CHECK = 3'd3;
   localparam upc_type UPC_DEC_MUL = 3'd4;
   localparam upc_type UPC_DEC_NORM = 3'd5;
   localparam upc_type UPC_DEC_FAIL = 3'd6;
   localparam upc_type UPC_FINISH = 3'd7;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_WRITE_ENTRY,
      UOP_LOAD_STATE,
      UOP_CHECK_STATE,
      UOP_MULTIPLY,
      UOP_RENORM,
      UOP_FINISH
   } uop_type;

   typedef struct packed {
      uop_type op;
      logic    respond;
      logic    branch;
      upc_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic [SYM_W-1:0]     sym;
      logic [FREQ_W-1:0]    freq;
      logic [TABLE_LOG-1:0] cum;
   } entry_type;

   function automatic logic in_bounds(input logic [STATE_W-1:0] s);
      return (s >= L_STATE) && (s < U_STATE);
   endfunction

   // Control store. A step that responds returns to the idle step; a step
   // with the branch bit jumps to its target when the datapath flags a failure.
   function automatic ctrl_word_type ucode_rom(input upc_type addr);
      ctrl_word_type cw;
      cw = '{op: UOP_NOP, respond: 1'b0, branch: 1'b0, target: UPC_IDLE};
      case (addr)
         UPC_LOAD: begin
            cw = '{op: UOP_WRITE_ENTRY, respond: 1'b1, branch: 1'b0, target: UPC_IDLE};
         end
         UPC_START: begin
            cw = '{op: UOP_LOAD_STATE, respond: 1'b1, branch: 1'b0, target: UPC_IDLE};
         end
         UPC_DEC_CHECK: begin
            cw = '{op: UOP_CHECK_STATE, respond: 1'b0, branch: 1'b1, target: UPC_DEC_FAIL};
         end
         UPC_DEC_MUL: begin
            cw = '{op: UOP_MULTIPLY, respond: 1'b0, branch: 1'b1, target: UPC_DEC_FAIL};
         end
         UPC_DEC_NORM: begin
            cw = '{op: UOP_RENORM, respond: 1'b1, branch: 1'b0, target: UPC_IDLE};
         end
         UPC_DEC_FAIL: begin
            cw = '{op: UOP_NOP, respond: 1'b1, branch: 1'b0, target: UPC_IDLE};
         end
         UPC_FINISH: begin
            cw = '{op: UOP_FINISH, respond: 1'b1, branch: 1'b0, target: UPC_IDLE};
         end
         default: begin
            cw = '{op: UOP_NOP, respond: 1'b0, branch: 1'b0, target: UPC_IDLE};
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== design/rans_byte_decoder.sv =====
// Byte-wise rANS decoder with a 64-bit coder state, run by a microcoded sequencer; uses rbd_pkg.
// Load, start and finish run one sequencer step, then the result cycle, in which the next
// transaction can be accepted. A decode runs state check with table read, multiply with
// entry check, add with up to two byte shifts, then the result; a latched error or bad state
// goes from check to the fail step, then the result. Synchronous reset clears the sequencer,
// coder state and error latch; the table is undefined until written. Results cannot stall.
module rans_byte_decoder
   import rbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [11:0] req_slot_index,
   input  logic [7:0]  req_entry_symbol,
   input  logic [12:0] req_entry_frequency,
   input  logic [11:0] req_entry_cumulative,
   input  logic [63:0] req_start_state,
   input  logic [15:0] req_window_bytes,
   input  logic [1:0]  req_window_count,
   input  logic        req_payload_remaining,
   output logic        rsp_valid,
   output logic [7:0]  rsp_symbol_out,
   output logic        rsp_symbol_valid,
   output logic [1:0]  rsp_bytes_used,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_block_done
);

   upc_type upc_ff, upc_in;
   ctrl_word_type cw;
   logic accept;
   logic fail;

   logic [TABLE_LOG-1:0] slot_ff;
   logic [SYM_W-1:0]     esym_ff;
   logic [FREQ_W-1:0]    efreq_ff;
   logic [TABLE_LOG-1:0] ecum_ff;
   logic [STATE_W-1:0]   init_ff;
   logic [15:0]          win_ff;
   logic [1:0]           wcount_ff;
   logic                 remain_ff;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [2:0]         err_ff, err_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [TABLE_LOG-1:0] diff_ff, diff_in;
   logic [SYM_W-1:0]   dsym_ff, dsym_in;

   entry_type table_mem [TABLE_SIZE];
   entry_type rd_ff;
   logic      mem_we;

   logic [SYM_W-1:0] o_sym;
   logic             o_valid;
   logic [1:0]       o_used;
   logic             o_done;

   logic             rsp_valid_ff;
   logic [SYM_W-1:0] rsp_sym_ff;
   logic             rsp_symv_ff;
   logic [1:0]       rsp_used_ff;
   logic [2:0]       rsp_err_ff;
   logic             rsp_done_ff;

   logic [TABLE_LOG-1:0] cur_slot;
   logic [TABLE_LOG+1:0] cum_end;
   logic                 table_bad;
   logic [SUM_W-1:0]     norm_s;
   logic [SUM_W-1:0]     norm_sum;
   logic [1:0]           norm_used;
   logic [1:0]           norm_avail;

   assign busy = (upc_ff != UPC_IDLE);
   assign accept = start && !busy;
   assign cw = ucode_rom(upc_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= req_slot_index[TABLE_LOG-1:0];
         esym_ff <= req_entry_symbol;
         efreq_ff <= FREQ_W'(req_entry_frequency);
         ecum_ff <= req_entry_cumulative[TABLE_LOG-1:0];
         init_ff <= req_start_state;
         win_ff <= req_window_bytes;
         wcount_ff <= req_window_count;
         remain_ff <= req_payload_remaining;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[slot_ff] <= '{sym: esym_ff, freq: efreq_ff, cum: ecum_ff};
      end
      rd_ff <= table_mem[cur_slot];
   end

   assign cur_slot = state_ff[TABLE_LOG-1:0];
   assign cum_end = {2'b0, rd_ff.cum} + (TABLE_LOG + 2)'(rd_ff.freq);
   assign table_bad = (rd_ff.freq == '0) || (cur_slot < rd_ff.cum)
                      || ({2'b0, cur_slot} >= cum_end);

   always_comb begin
      norm_sum = {1'b0, prod_ff} + SUM_W'(diff_ff);
      norm_avail = (wcount_ff == 2'd3) ? 2'd2 : wcount_ff;
      norm_s = norm_sum;
      norm_used = 2'd0;
      if (norm_s < L_SUM && norm_avail != 2'd0) begin
         norm_s = {norm_s[SUM_W-9:0], win_ff[15:8]};
         norm_used = 2'd1;
         if (norm_s < L_SUM && norm_avail == 2'd2) begin
            norm_s = {norm_s[SUM_W-9:0], win_ff[7:0]};
            norm_used = 2'd2;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      err_in = err_ff;
      prod_in = prod_ff;
      diff_in = diff_ff;
      dsym_in = dsym_ff;
      fail = 1'b0;
      mem_we = 1'b0;
      o_sym = '0;
      o_valid = 1'b0;
      o_used = 2'd0;
      o_done = 1'b0;
      case (cw.op)
         UOP_WRITE_ENTRY: begin
            mem_we = 1'b1;
         end
         UOP_LOAD_STATE: begin
            state_in = init_ff;
            err_in = in_bounds(init_ff) ? ERR_NONE : ERR_STATE;
         end
         UOP_CHECK_STATE: begin
            if (err_ff != ERR_NONE) begin
               fail = 1'b1;
            end else if (!in_bounds(state_ff)) begin
               fail = 1'b1;
               err_in = ERR_STATE;
            end
         end
         UOP_MULTIPLY: begin
            if (table_bad) begin
               fail = 1'b1;
               err_in = ERR_TABLE;
            end else begin
               prod_in = PROD_W'(rd_ff.freq) * PROD_W'(state_ff[LB_LOG+7:TABLE_LOG]);
               diff_in = cur_slot - rd_ff.cum;
               dsym_in = rd_ff.sym;
            end
         end
         UOP_RENORM: begin
            o_used = norm_used;
            if (norm_s < L_SUM) begin
               err_in = ERR_TRUNC;
            end else if (norm_s >= U_SUM) begin
               err_in = ERR_STATE;
            end else begin
               state_in = STATE_W'(norm_s);
               o_sym = dsym_ff;
               o_valid = 1'b1;
            end
         end
         UOP_FINISH: begin
            o_done = 1'b1;
            if (err_ff == ERR_NONE) begin
               if (state_ff != L_STATE) begin
                  err_in = ERR_TERM;
               end else if (remain_ff) begin
                  err_in = ERR_TRAIL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      upc_in = upc_ff;
      if (upc_ff == UPC_IDLE) begin
         if (accept) begin
            case (req_command)
               CMD_LOAD: upc_in = UPC_LOAD;
               CMD_START: upc_in = UPC_START;
               CMD_DECODE: upc_in = UPC_DEC_CHECK;
               CMD_FINISH: upc_in = UPC_FINISH;
               default: upc_in = UPC_IDLE;
            endcase
         end
      end else if (cw.respond) begin
         upc_in = UPC_IDLE;
      end else if (cw.branch && fail) begin
         upc_in = cw.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
         state_ff <= '0;
         err_ff <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         state_ff <= state_in;
         err_ff <= err_in;
         rsp_valid_ff <= cw.respond;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      diff_ff <= diff_in;
      dsym_ff <= dsym_in;
      if (cw.respond) begin
         rsp_sym_ff <= o_sym;
         rsp_symv_ff <= o_valid;
         rsp_used_ff <= o_used;
         rsp_err_ff <= err_in;
         rsp_done_ff <= o_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_symbol_out = rsp_sym_ff;
   assign rsp_symbol_valid = rsp_symv_ff;
   assign rsp_bytes_used = rsp_used_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_block_done = rsp_done_ff;

   // A response always lands in the idle step, so the next transaction can follow.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while the sequencer is busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the sequencer");

   a_symbol_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_symbol_valid) |-> (rsp_error_code == ERR_NONE && !rsp_block_done))
      else $error("decoded symbol reported together with an error or finish");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE && upc_ff != UPC_START) |=> (err_ff == $past(err_ff)))
      else $error("latched error changed without a start transaction");

endmodule

// ===== tb/rans_byte_decoder_tb.sv =====
// Self-checking testbench for rans_byte_decoder: directed table rows, some with fixed
// outcomes, then encoded blocks with random content mixed with noise transactions, others
// checked against a local predictor. Depends on rbd_pkg and rans_byte_decoder only.
module rans_byte_decoder_tb
   import rbd_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 370;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] slot_index;
      logic [7:0]  entry_symbol;
      logic [12:0] entry_frequency;
      logic [11:0] entry_cumulative;
      logic [63:0] start_state;
      logic [15:0] window_bytes;
      logic [1:0]  window_count;
      logic        payload_remaining;
   } dec_req_type;

   typedef struct packed {
      logic [7:0] symbol_out;
      logic       symbol_valid;
      logic [1:0] bytes_used;
      logic [2:0] error_code;
      logic       block_done;
   } dec_rsp_type;

   typedef struct packed {
      dec_req_type req;
      logic        typed;
      dec_rsp_type rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [11:0] req_slot_index;
   logic [7:0]  req_entry_symbol;
   logic [12:0] req_entry_frequency;
   logic [11:0] req_entry_cumulative;
   logic [63:0] req_start_state;
   logic [15:0] req_window_bytes;
   logic [1:0]  req_window_count;
   logic        req_payload_remaining;
   logic        rsp_valid;
   logic [7:0]  rsp_symbol_out;
   logic        rsp_symbol_valid;
   logic [1:0]  rsp_bytes_used;
   logic [2:0]  rsp_error_code;
   logic        rsp_block_done;

   entry_type   tbl_copy [TABLE_SIZE];
   bit          tbl_loaded [TABLE_SIZE];
   entry_type   coding_tbl [TABLE_SIZE];
   logic [63:0] coder_x = '0;
   logic [2:0]  latched_err = ERR_NONE;

   dec_rsp_type outcome_q [$];
   dir_row_type dir_rows [$];
   logic [7:0]  byte_stream [$];
   int          gap_pct = 9;
   int          items_sent = 0;
   int          mismatches = 0;
   int          cycles = 0;

   rans_byte_decoder uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_slot_index(req_slot_index),
      .req_entry_symbol(req_entry_symbol),
      .req_entry_frequency(req_entry_frequency),
      .req_entry_cumulative(req_entry_cumulative),
      .req_start_state(req_start_state),
      .req_window_bytes(req_window_bytes),
      .req_window_count(req_window_count),
      .req_payload_remaining(req_payload_remaining),
      .rsp_valid(rsp_valid),
      .rsp_symbol_out(rsp_symbol_out),
      .rsp_symbol_valid(rsp_symbol_valid),
      .rsp_bytes_used(rsp_bytes_used),
      .rsp_error_code(rsp_error_code),
      .rsp_block_done(rsp_block_done)
   );

   always #6 clock = ~clock;

   function automatic bit state_legal(input logic [63:0] x);
      return (x >= L_STATE) && (x < (L_STATE << 8));
   endfunction

   function automatic dec_rsp_type step_decoder(input dec_req_type r);
      dec_rsp_type  o;
      logic [63:0]  x;
      logic [127:0] wide;
      logic [2:0]   fault;
      logic [11:0]  slot;
      entry_type    e;
      int           used;
      int           avail;
      o = '0;
      case (r.command)
         CMD_LOAD: begin
            tbl_copy[r.slot_index] = {r.entry_symbol, r.entry_frequency, r.entry_cumulative};
            tbl_loaded[r.slot_index] = 1'b1;
         end
         CMD_START: begin
            coder_x = r.start_state;
            latched_err = state_legal(coder_x) ? ERR_NONE : ERR_STATE;
         end
         CMD_DECODE: begin
            if (latched_err == ERR_NONE) begin
               x = coder_x;
               fault = ERR_NONE;
               used = 0;
               avail = (r.window_count > 2) ? 2 : int'(r.window_count);
               e = '0;
               if (!state_legal(x)) begin
                  fault = ERR_STATE;
               end else begin
                  slot = x[TABLE_LOG-1:0];
                  e = tbl_copy[slot];
                  if (e.freq == 0 || slot < e.cum ||
                      int'(slot) >= int'(e.cum) + int'(e.freq)) begin
                     fault = ERR_TABLE;
                  end else begin
                     wide = 128'(e.freq) * 128'(x >> TABLE_LOG) + 128'(slot - e.cum);
                     if (wide[127:64] != '0) begin
                        fault = ERR_OVF;
                     end else begin
                        x = wide[63:0];
                        while (x < L_STATE && fault == ERR_NONE) begin
                           if (used >= avail) begin
                              fault = ERR_TRUNC;
                           end else if (x > (64'hFFFF_FFFF_FFFF_FFFF >> 8)) begin
                              fault = ERR_OVF;
                           end else begin
                              x = {x[55:0], (used == 0) ? r.window_bytes[15:8]
                                                        : r.window_bytes[7:0]};
                              used++;
                           end
                        end
                        if (fault == ERR_NONE && !state_legal(x)) fault = ERR_STATE;
                     end
                  end
               end
               o.bytes_used = 2'(used);
               if (fault == ERR_NONE) begin
                  coder_x = x;
                  o.symbol_out = e.sym;
                  o.symbol_valid = 1'b1;
               end else begin
                  latched_err = fault;
               end
            end
         end
         default: begin
            o.block_done = 1'b1;
            if (latched_err == ERR_NONE) begin
               if (coder_x != L_STATE) latched_err = ERR_TERM;
               else if (r.payload_remaining) latched_err = ERR_TRAIL;
            end
         end
      endcase
      o.error_code = latched_err;
      return o;
   endfunction

   function automatic dec_req_type rand_req();
      dec_req_type r;
      r.command = 2'($urandom_range(3));
      r.slot_index = 12'($urandom_range(4095));
      r.entry_symbol = 8'($urandom_range(255));
      r.entry_frequency = 13'($urandom_range(4096));
      r.entry_cumulative = 12'($urandom_range(4095));
      r.start_state = {$urandom, $urandom};
      r.window_bytes = 16'($urandom_range(65535));
      r.window_count = 2'($urandom_range(3));
      r.payload_remaining = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic dec_req_type mk_load(input logic [11:0] slot, input logic [7:0] sym,
                                           input logic [12:0] freq, input logic [11:0] cum);
      dec_req_type r;
      r = rand_req();
      r.command = CMD_LOAD;
      r.slot_index = slot;
      r.entry_symbol = sym;
      r.entry_frequency = freq;
      r.entry_cumulative = cum;
      return r;
   endfunction

   function automatic dec_req_type mk_start(input logic [63:0] x);
      dec_req_type r;
      r = rand_req();
      r.command = CMD_START;
      r.start_state = x;
      return r;
   endfunction

   function automatic dec_req_type mk_decode(input logic [15:0] win, input logic [1:0] cnt);
      dec_req_type r;
      r = rand_req();
      r.command = CMD_DECODE;
      r.window_bytes = win;
      r.window_count = cnt;
      return r;
   endfunction

   function automatic dec_req_type mk_finish(input logic rem);
      dec_req_type r;
      r = rand_req();
      r.command = CMD_FINISH;
      r.payload_remaining = rem;
      return r;
   endfunction

   function automatic dec_rsp_type outcome(input logic [7:0] sym, input logic valid,
                                           input logic [1:0] used, input logic [2:0] err,
                                           input logic done);
      return {sym, valid, used, err, done};
   endfunction

   function automatic void add_row(input dec_req_type q, input logic typed,
                                   input dec_rsp_type o);
      dir_rows.push_back({q, typed, o});
   endfunction

   task automatic flag(input string msg);
      $display("[cycle %0d] mismatch: %s", cycles, msg);
      mismatches++;
   endtask

   task automatic drive(input dec_req_type r);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= r.command;
      req_slot_index <= r.slot_index;
      req_entry_symbol <= r.entry_symbol;
      req_entry_frequency <= r.entry_frequency;
      req_entry_cumulative <= r.entry_cumulative;
      req_start_state <= r.start_state;
      req_window_bytes <= r.window_bytes;
      req_window_count <= r.window_count;
      req_payload_remaining <= r.payload_remaining;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send(input dec_req_type r, output dec_rsp_type res);
      res = step_decoder(r);
      outcome_q.push_back(res);
      drive(r);
   endtask

   // A decode from a legal state reads the slot under the state, so make sure it holds
   // something written; faithful mode also restores the entry of the current code table.
   task automatic prepare_slot(input bit faithful);
      dec_req_type r;
      dec_rsp_type res;
      logic [11:0] slot;
      slot = coder_x[TABLE_LOG-1:0];
      if (latched_err == ERR_NONE && state_legal(coder_x) &&
          (!tbl_loaded[slot] || (faithful && tbl_copy[slot] != coding_tbl[slot]))) begin
         r = mk_load(slot, 8'($urandom), 13'($urandom_range(4096)), 12'($urandom));
         if (faithful || $urandom_range(1)) begin
            {r.entry_symbol, r.entry_frequency, r.entry_cumulative} = coding_tbl[slot];
         end
         send(r, res);
      end
   endtask

   task automatic build_code_table();
      int         nsym;
      int         remaining;
      int         base;
      int         f;
      int         k;
      int         s;
      logic [7:0] sym;
      case ($urandom_range(5))
         0: nsym = 1;
         1: nsym = 256;
         default: nsym = $urandom_range(2, 40);
      endcase
      remaining = TABLE_SIZE;
      base = 0;
      for (k = 0; k < nsym; k++) begin
         if (k == nsym - 1) f = remaining;
         else f = $urandom_range(1, (remaining - (nsym - 1 - k) + 1) / 2);
         sym = (nsym == 256) ? 8'(k) : 8'($urandom);
         for (s = base; s < base + f; s++) coding_tbl[s] = {sym, 13'(f), 12'(base)};
         base += f;
         remaining -= f;
      end
   endtask

   // Encodes len random symbols backward from the final state; the bytes land in
   // byte_stream in the order the decoder consumes them.
   task automatic encode_block(input int len, output logic [63:0] x0);
      logic [63:0] x;
      entry_type   e;
      int          k;
      x = L_STATE;
      byte_stream.delete();
      for (k = 0; k < len; k++) begin
         e = coding_tbl[$urandom_range(TABLE_SIZE - 1)];
         while (x >= ((L_STATE >> TABLE_LOG) << 8) * e.freq) begin
            byte_stream.push_front(x[7:0]);
            x = x >> 8;
         end
         x = ((x / e.freq) << TABLE_LOG) + (x % e.freq) + e.cum;
      end
      x0 = x;
   endtask

   task automatic run_block();
      dec_req_type r;
      dec_rsp_type res;
      logic [63:0] x0;
      logic [7:0]  b_hi;
      logic [7:0]  b_lo;
      int          len;
      int          cut;
      int          k;
      int          ptr;
      int          n;
      if ($urandom_range(3) == 0) build_code_table();
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      encode_block(len, x0);
      n = byte_stream.size();
      if (n > 0 && $urandom_range(11) == 0) begin
         byte_stream[$urandom_range(n - 1)] ^= 8'(1 << $urandom_range(7));
      end
      cut = ($urandom_range(24) == 0) ? $urandom_range(len - 1) : len;
      send(mk_start(x0), res);
      ptr = 0;
      for (k = 0; k < cut; k++) begin
         if ($urandom_range(29) == 0) begin
            send(mk_load(12'($urandom), 8'($urandom), 13'($urandom_range(4096)),
                         12'($urandom)), res);
         end
         b_hi = (ptr < n) ? byte_stream[ptr] : 8'($urandom);
         b_lo = (ptr + 1 < n) ? byte_stream[ptr + 1] : 8'($urandom);
         r = mk_decode({b_hi, b_lo}, (n - ptr >= 2) ? 2'd2 : 2'(n - ptr));
         if (r.window_count == 2'd2 && $urandom_range(4) == 0) r.window_count = 2'd3;
         if ($urandom_range(39) == 0) r.window_count = 2'($urandom_range(1));
         prepare_slot(1'b1);
         send(r, res);
         ptr += int'(res.bytes_used);
      end
      send(mk_finish((ptr < n) || ($urandom_range(19) == 0)), res);
   endtask

   task automatic noise_item();
      dec_req_type r;
      dec_rsp_type res;
      r = rand_req();
      if (r.command == CMD_START && $urandom_range(1)) begin
         r.start_state = L_STATE + ({$urandom, $urandom} % (L_STATE * 255));
      end
      if (r.command == CMD_DECODE) prepare_slot(1'b0);
      send(r, res);
   endtask

   always @(posedge clock) begin : rsp_check
      dec_rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid === 1'b1) begin
         if (outcome_q.size() == 0) begin
            flag("response with no transaction outstanding");
         end else begin
            want = outcome_q.pop_front();
            if (rsp_symbol_out !== want.symbol_out)
               flag($sformatf("symbol_out %0h, want %0h", rsp_symbol_out, want.symbol_out));
            if (rsp_symbol_valid !== want.symbol_valid)
               flag($sformatf("symbol_valid %0b, want %0b", rsp_symbol_valid,
                              want.symbol_valid));
            if (rsp_bytes_used !== want.bytes_used)
               flag($sformatf("bytes_used %0d, want %0d", rsp_bytes_used, want.bytes_used));
            if (rsp_error_code !== want.error_code)
               flag($sformatf("error_code %0d, want %0d", rsp_error_code, want.error_code));
            if (rsp_block_done !== want.block_done)
               flag($sformatf("block_done %0b, want %0b", rsp_block_done, want.block_done));
         end
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      dec_rsp_type res;
      int          phase;
      int          target;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_LOAD;
      req_slot_index <= '0;
      req_entry_symbol <= '0;
      req_entry_frequency <= '0;
      req_entry_cumulative <= '0;
      req_start_state <= '0;
      req_window_bytes <= '0;
      req_window_count <= '0;
      req_payload_remaining <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(mk_decode(16'hFFFF, 2'd2), 1, outcome(0, 0, 0, ERR_STATE, 0));
      add_row(mk_start(L_STATE - 1), 1, outcome(0, 0, 0, ERR_STATE, 0));
      add_row(mk_start(L_STATE << 8), 1, outcome(0, 0, 0, ERR_STATE, 0));
      add_row(mk_start('1), 1, outcome(0, 0, 0, ERR_STATE, 0));
      add_row(mk_load(12'hFFF, 8'hFF, 13'd4096, 12'd0), 1, outcome(0, 0, 0, ERR_STATE, 0));
      add_row(mk_load(12'h000, 8'h00, 13'd4096, 12'd0), 1, outcome(0, 0, 0, ERR_STATE, 0));
      add_row(mk_start(L_STATE), 1, outcome(0, 0, 0, ERR_NONE, 0));
      add_row(mk_decode(16'h0000, 2'd0), 1, outcome(0, 1, 0, ERR_NONE, 0));
      add_row(mk_finish(1'b0), 1, outcome(0, 0, 0, ERR_NONE, 1));
      add_row(mk_finish(1'b1), 1, outcome(0, 0, 0, ERR_TRAIL, 1));
      add_row(mk_start((L_STATE << 8) - 1), 1, outcome(0, 0, 0, ERR_NONE, 0));
      add_row(mk_decode(16'h0000, 2'd0), 1, outcome(8'hFF, 1, 0, ERR_NONE, 0));
      add_row(mk_finish(1'b0), 1, outcome(0, 0, 0, ERR_TERM, 1));
      add_row(mk_load(12'hFFF, 8'hA5, 13'd0, 12'hFFF), 1, outcome(0, 0, 0, ERR_TERM, 0));
      add_row(mk_start((L_STATE << 8) - 1), 1, outcome(0, 0, 0, ERR_NONE, 0));
      add_row(mk_decode(16'hFFFF, 2'd2), 1, outcome(0, 0, 0, ERR_TABLE, 0));
      add_row(mk_decode(16'hFFFF, 2'd2), 1, outcome(0, 0, 0, ERR_TABLE, 0));
      add_row(mk_finish(1'b0), 1, outcome(0, 0, 0, ERR_TABLE, 1));
      add_row(mk_load(12'h001, 8'h5A, 13'd1, 12'd1), 1, outcome(0, 0, 0, ERR_TABLE, 0));
      add_row(mk_start(L_STATE + 1), 1, outcome(0, 0, 0, ERR_NONE, 0));
      add_row(mk_decode(16'hFFFF, 2'd1), 1, outcome(0, 0, 1, ERR_TRUNC, 0));
      add_row(mk_start(L_STATE + 1), 1, outcome(0, 0, 0, ERR_NONE, 0));
      add_row(mk_decode(16'hFFFF, 2'd3), 1, outcome(8'h5A, 1, 2, ERR_NONE, 0));
      add_row(mk_load(12'h002, 8'h3C, 13'd5, 12'd3), 0, '0);
      add_row(mk_start(L_STATE + 2), 0, '0);
      add_row(mk_decode(16'h1234, 2'd2), 0, '0);
      add_row(mk_load(12'hFFF, 8'h77, 13'h1FFF, 12'hFFF), 0, '0);
      add_row(mk_start(L_STATE + 64'hFFF), 0, '0);
      add_row(mk_decode(16'h4321, 2'd2), 0, '0);

      foreach (dir_rows[i]) begin
         res = step_decoder(dir_rows[i].req);
         outcome_q.push_back(dir_rows[i].typed ? dir_rows[i].rsp : res);
         drive(dir_rows[i].req);
      end

      build_code_table();
      for (phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 9 : (phase == 1) ? 55 : 0;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(99) < 70) run_block();
            else noise_item();
         end
      end
      start <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
